@@ rtl/core/bse_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the burning ship escape-time core.
package bse_pkg;

	localparam int IMG_WIDTH_DEF  = 1024;
	localparam int IMG_HEIGHT_DEF = 1024;
	localparam int FRAC_BITS_DEF  = 24;

	localparam int COORD_W     = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int ITER_W      = 12;
	localparam int RGB_W       = 24;
	localparam int COLOR_W     = 32;
	localparam int SAT_W       = 66;
	localparam int RAMP_W      = RGB_W + ITER_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	localparam logic [RGB_W-1:0] WHITE_RGB  = 24'hFFFFFF;
	localparam logic [13:0]      COLOR_STEP = 14'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZOOM         = 3'd0,
		CFG_OFFSET_REAL  = 3'd1,
		CFG_OFFSET_IMAG  = 3'd2,
		CFG_ITER_LIMIT   = 3'd3,
		CFG_ESC_THRESH   = 3'd4,
		CFG_SEED_COLOR   = 3'd5,
		CFG_COLOR_OFFSET = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [30:0]        zoom_factor;
		logic signed [31:0] offset_real;
		logic signed [31:0] offset_imag;
		logic [ITER_W-1:0]  iteration_limit;
		logic [30:0]        escape_threshold;
		logic [RGB_W-1:0]   seed_color;
		logic [7:0]         color_offset;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		zoom_factor:      31'd16777216,
		offset_real:      32'sd0,
		offset_imag:      32'sd0,
		iteration_limit:  12'd256,
		escape_threshold: 31'd67108864,
		seed_color:       24'd0,
		color_offset:     8'd0
	};

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} pixel_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_column;
		logic [COORD_W-1:0] out_row;
		logic [COLOR_W-1:0] pixel_color;
		logic               escaped;
	} pixel_out_t;

	// one mapped pixel handed from front to back
	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic signed [31:0] cr;
		logic signed [31:0] ci;
	} job_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MAP,
		F_SAT,
		F_MUL,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_CALC,
		B_DIV,
		B_FIN
	} back_state_t;

	// clamp a wide signed value into the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic in_range;
		in_range = (v[SAT_W-1:31] == '0) || (v[SAT_W-1:31] == '1);
		if (in_range) begin
			return v[31:0];
		end else if (v[SAT_W-1]) begin
			return {1'b1, 31'b0};
		end else begin
			return {1'b0, {31{1'b1}}};
		end
	endfunction

endpackage

@@ rtl/core/bse_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts a pixel, maps both coordinates to the start point, queues it.
module bse_front #(
	parameter int IMG_WIDTH  = bse_pkg::IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = bse_pkg::IMG_HEIGHT_DEF,
	parameter int FRAC_BITS  = bse_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bse_pkg::pixel_in_t item,
	output logic               busy,
	input  bse_pkg::cfg_t      cfg,
	output logic               push,
	output bse_pkg::job_t      job,
	input  logic               full
);
	import bse_pkg::*;

	localparam int QW   = COORD_W + FRAC_BITS + 2;
	// coord * 2^(F+2) / extent as (coord * RM) >> RT; the rounding error of RM
	// times any coord below 2^COORD_W stays under one unit, so the floor is exact
	localparam int     RT_C = COORD_W + $clog2(IMG_WIDTH);
	localparam int     RT_R = COORD_W + $clog2(IMG_HEIGHT);
	localparam longint RM_C = ((longint'(1) << (FRAC_BITS + 2 + RT_C)) +
		longint'(IMG_WIDTH) - 1) / longint'(IMG_WIDTH);
	localparam longint RM_R = ((longint'(1) << (FRAC_BITS + 2 + RT_R)) +
		longint'(IMG_HEIGHT) - 1) / longint'(IMG_HEIGHT);
	localparam int     PW_C = QW + RT_C + 1;
	localparam int     PW_R = QW + RT_R + 1;
	localparam logic [PW_C-1:0] RMV_C = PW_C'(RM_C);
	localparam logic [PW_R-1:0] RMV_R = PW_R'(RM_R);
	// 2.0 in the fixed-point format
	localparam logic [QW+1:0]      MAP_BIAS = {{(QW - FRAC_BITS){1'b0}}, 1'b1,
		{(FRAC_BITS + 1){1'b0}}};

	front_state_t state_q, state_d;

	logic [COORD_W-1:0] col_q, row_q;
	logic [QW-1:0]      quot_c_q, quot_r_q;
	logic signed [31:0] m_r_q, m_i_q;
	logic signed [63:0] prod_r_q, prod_i_q;

	logic [PW_C-1:0]    qprod_c;
	logic [PW_R-1:0]    qprod_r;
	logic [QW-1:0]      quot_c, quot_r;
	logic signed [QW+1:0] map_c, map_r;
	logic signed [31:0] zoom_s;
	logic signed [63:0] mul_r, mul_i;
	logic signed [63:0] sh_r, sh_i;
	logic signed [SAT_W-1:0] sum_r, sum_i;
	logic               accept;

	// constant multiply by the scaled reciprocal of the image extent
	assign qprod_c = PW_C'(col_q) * RMV_C;
	assign qprod_r = PW_R'(row_q) * RMV_R;
	assign quot_c  = QW'(qprod_c >> RT_C);
	assign quot_r  = QW'(qprod_r >> RT_R);

	assign map_c = $signed({2'b00, quot_c_q}) - $signed(MAP_BIAS);
	assign map_r = $signed({2'b00, quot_r_q}) - $signed(MAP_BIAS);

	assign zoom_s = $signed({1'b0, cfg.zoom_factor});
	assign mul_r  = m_r_q * zoom_s;
	assign mul_i  = m_i_q * zoom_s;

	assign sh_r  = prod_r_q >>> FRAC_BITS;
	assign sh_i  = prod_i_q >>> FRAC_BITS;
	assign sum_r = SAT_W'(sh_r) + SAT_W'($signed(cfg.offset_real));
	assign sum_i = SAT_W'(sh_i) + SAT_W'($signed(cfg.offset_imag));

	assign job.column = col_q;
	assign job.row    = row_q;
	assign job.cr     = sat32(sum_r);
	assign job.ci     = sat32(sum_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		accept  = 1'b0;
		push    = 1'b0;
		busy    = 1'b1;
		case (state_q)
			F_IDLE: begin
				busy = 1'b0;
				if (start) begin
					accept  = 1'b1;
					state_d = F_MAP;
				end
			end
			F_MAP: state_d = F_SAT;
			F_SAT: state_d = F_MUL;
			F_MUL: state_d = F_PUSH;
			F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= item.column;
			row_q <= item.row;
		end
		if (state_q == F_MAP) begin
			quot_c_q <= quot_c;
			quot_r_q <= quot_r;
		end
		if (state_q == F_SAT) begin
			m_r_q <= sat32(SAT_W'(map_c));
			m_i_q <= sat32(SAT_W'(map_r));
		end
		if (state_q == F_MUL) begin
			prod_r_q <= mul_r;
			prod_i_q <= mul_i;
		end
	end

endmodule

@@ rtl/core/bse_fifo.sv @@
`timescale 1ns / 1ps
// Two-entry job queue between the mapping front end and the iteration back end.
module bse_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bse_pkg::job_t wr_data,
	output logic          full,
	input  logic          pop,
	output bse_pkg::job_t rd_data,
	output logic          empty
);
	import bse_pkg::*;

	job_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W:0] wr_ptr_q, rd_ptr_q;

	assign empty   = wr_ptr_q == rd_ptr_q;
	assign full    = (wr_ptr_q[QPTR_W] != rd_ptr_q[QPTR_W]) &&
		(wr_ptr_q[QPTR_W-1:0] == rd_ptr_q[QPTR_W-1:0]);
	assign rd_data = mem_q[rd_ptr_q[QPTR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q[QPTR_W-1:0]] <= wr_data;
		end
	end

endmodule

@@ rtl/core/bse_back.sv @@
`timescale 1ns / 1ps
// Back end: burning ship iteration, escape test and colour ramp division.
module bse_back #(
	parameter int FRAC_BITS = bse_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	output logic                pop,
	input  bse_pkg::job_t       job,
	input  bse_pkg::cfg_t       cfg,
	output logic                done,
	output bse_pkg::pixel_out_t result
);
	import bse_pkg::*;

	localparam int DIV_CNT_W = $clog2(RAMP_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RAMP_W - 1);

	function automatic logic [30:0] sat_abs(input logic signed [31:0] v);
		logic [31:0] neg;
		neg = 32'(-v);
		if (!v[31]) begin
			return v[30:0];
		end else if (v[30:0] == '0) begin
			return {31{1'b1}};
		end else begin
			return neg[30:0];
		end
	endfunction

	back_state_t state_q, state_d;

	logic [COORD_W-1:0] col_q, row_q;
	logic signed [31:0] cr_q, ci_q, zr_q, zi_q;
	logic [ITER_W-1:0]  it_q;
	logic [61:0]        aa_q, bb_q, ab_q;
	logic               zr_min_q, zi_min_q;
	logic [RAMP_W-1:0]  dvd_q;
	logic [ITER_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	pixel_out_t         result_q;
	logic               done_q;

	logic [30:0]        a_abs, b_abs;
	logic [61:0]        aa_d, bb_d, ab_d;
	logic [62:0]        sq_r, sq_i;
	logic [63:0]        mag, bound;
	logic               esc_hit, at_limit;
	logic signed [62:0] diff;
	logic signed [62:0] diff_sh;
	logic [61:0]        two_ab;
	logic signed [SAT_W-1:0] sum_r, sum_i;
	logic [ITER_W-1:0]  esc_idx;
	logic [RGB_W-1:0]   span;
	logic [RAMP_W-1:0]  ramp_prod;
	logic [ITER_W:0]    trial;
	logic               ge;
	logic [ITER_W-1:0]  rem_d;
	logic [COLOR_W-1:0] esc_color;
	logic               load_job, step_z, load_div, emit_plain, emit_esc;

	// multiply phase operands
	assign a_abs = sat_abs(zr_q);
	assign b_abs = sat_abs(zi_q);
	assign aa_d  = a_abs * a_abs;
	assign bb_d  = b_abs * b_abs;
	assign ab_d  = a_abs * b_abs;

	// |z|^2 of the current z: zr^2 equals |zr|^2 except at the most negative value
	assign sq_r     = zr_min_q ? {1'b1, 62'b0} : {1'b0, aa_q};
	assign sq_i     = zi_min_q ? {1'b1, 62'b0} : {1'b0, bb_q};
	assign mag      = {1'b0, sq_r} + {1'b0, sq_i};
	assign bound    = 64'({cfg.escape_threshold, {FRAC_BITS{1'b0}}});
	assign esc_hit  = (it_q != '0) && (mag >= bound);
	assign at_limit = it_q == cfg.iteration_limit;

	assign diff    = $signed({1'b0, aa_q}) - $signed({1'b0, bb_q});
	assign diff_sh = diff >>> FRAC_BITS;
	assign two_ab  = ab_q >> (FRAC_BITS - 1);
	assign sum_r   = SAT_W'(diff_sh) + SAT_W'(cr_q);
	assign sum_i   = SAT_W'($signed({1'b0, two_ab})) + SAT_W'(ci_q);

	assign esc_idx   = it_q - 1'b1;
	assign span      = WHITE_RGB - cfg.seed_color;
	assign ramp_prod = span * esc_idx;

	// restoring division of the ramp product by the iteration limit
	assign trial = {rem_q, dvd_q[RAMP_W-1]};
	assign ge    = trial >= {1'b0, cfg.iteration_limit};
	assign rem_d = ge ? ITER_W'(trial - {1'b0, cfg.iteration_limit}) : ITER_W'(trial);

	assign esc_color = COLOR_W'(cfg.seed_color) + COLOR_W'(dvd_q) +
		COLOR_W'(cfg.color_offset) * COLOR_W'(COLOR_STEP);

	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit_plain || emit_esc;
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		load_job   = 1'b0;
		step_z     = 1'b0;
		load_div   = 1'b0;
		emit_plain = 1'b0;
		emit_esc   = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop      = 1'b1;
					load_job = 1'b1;
					state_d  = B_MUL;
				end
			end
			B_MUL: state_d = B_CALC;
			B_CALC: begin
				if (esc_hit) begin
					load_div = 1'b1;
					state_d  = B_DIV;
				end else if (at_limit) begin
					emit_plain = 1'b1;
					state_d    = B_IDLE;
				end else begin
					step_z  = 1'b1;
					state_d = B_MUL;
				end
			end
			B_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = B_FIN;
				end
			end
			B_FIN: begin
				emit_esc = 1'b1;
				state_d  = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			col_q <= job.column;
			row_q <= job.row;
			cr_q  <= job.cr;
			ci_q  <= job.ci;
			zr_q  <= job.cr;
			zi_q  <= job.ci;
			it_q  <= '0;
		end
		if (state_q == B_MUL) begin
			aa_q     <= aa_d;
			bb_q     <= bb_d;
			ab_q     <= ab_d;
			zr_min_q <= zr_q == {1'b1, 31'b0};
			zi_min_q <= zi_q == {1'b1, 31'b0};
		end
		if (step_z) begin
			zr_q <= sat32(sum_r);
			zi_q <= sat32(sum_i);
			it_q <= it_q + 1'b1;
		end
		if (load_div) begin
			dvd_q <= ramp_prod;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == B_DIV) begin
			dvd_q <= {dvd_q[RAMP_W-2:0], ge};
			rem_q <= rem_d;
			cnt_q <= cnt_q + 1'b1;
		end
		if (emit_plain) begin
			result_q.out_column  <= col_q;
			result_q.out_row     <= row_q;
			result_q.pixel_color <= COLOR_W'(cfg.seed_color);
			result_q.escaped     <= 1'b0;
		end
		if (emit_esc) begin
			result_q.out_column  <= col_q;
			result_q.out_row     <= row_q;
			result_q.pixel_color <= esc_color;
			result_q.escaped     <= 1'b1;
		end
	end

endmodule

@@ rtl/core/burning_ship_escape_time.sv @@
`timescale 1ns / 1ps
// Top level of the burning ship escape-time pixel core: config registers and wiring.
//
//  channel  | handshake      | payload
//  ---------+----------------+------------------------------------------------
//  pixel in | start / busy   | item   (column, row)
//  result   | done (strobe)  | result (out_column, out_row, pixel_color, escaped)
//  config   | cfg_we         | cfg_index, cfg_data
//
// Front end: an accept state, then a state each for reciprocal-multiply coordinate
// mapping, saturation and zoom multiply, then the queue push, which waits while full.
// Back end: a pop state, then multiply and check states per escape check on the shared
// complex-square multipliers (limit+1 checks for a pixel that stays bounded), plus
// bit-serial colour division for an escaped pixel. The back end sets the rate.
// Reset loads register defaults and empties the queue; results are one-cycle strobes.
module burning_ship_escape_time #(
	parameter int IMG_WIDTH  = bse_pkg::IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = bse_pkg::IMG_HEIGHT_DEF,
	parameter int FRAC_BITS  = bse_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  bse_pkg::pixel_in_t                item,
	output logic                              busy,
	output logic                              done,
	output bse_pkg::pixel_out_t               result,
	input  logic                              cfg_we,
	input  logic [bse_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bse_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bse_pkg::*;

	cfg_t cfg_q;
	job_t push_job, pop_job;
	logic push, full, pop, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ZOOM:         cfg_q.zoom_factor      <= cfg_data[30:0];
				CFG_OFFSET_REAL:  cfg_q.offset_real      <= cfg_data;
				CFG_OFFSET_IMAG:  cfg_q.offset_imag      <= cfg_data;
				CFG_ITER_LIMIT:   cfg_q.iteration_limit  <= cfg_data[ITER_W-1:0];
				CFG_ESC_THRESH:   cfg_q.escape_threshold <= cfg_data[30:0];
				CFG_SEED_COLOR:   cfg_q.seed_color       <= cfg_data[RGB_W-1:0];
				CFG_COLOR_OFFSET: cfg_q.color_offset     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	bse_front #(
		.IMG_WIDTH (IMG_WIDTH),
		.IMG_HEIGHT(IMG_HEIGHT),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.busy  (busy),
		.cfg   (cfg_q),
		.push  (push),
		.job   (push_job),
		.full  (full)
	);

	bse_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(push_job),
		.full   (full),
		.pop    (pop),
		.rd_data(pop_job),
		.empty  (empty)
	);

	bse_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (empty),
		.pop   (pop),
		.job   (pop_job),
		.cfg   (cfg_q),
		.done  (done),
		.result(result)
	);

endmodule

@@ rtl/core/bse_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the escape-time core, bound to the top level.
module bse_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	// pixels accepted and not yet delivered
	logic [3:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if ((start && !busy) && !done) begin
			pend_q <= pend_q + 1'b1;
		end else if (!(start && !busy) && done) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an accepted beat");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_done_has_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pend_q != 4'd0)
		else $error("result with no pixel outstanding");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd4)
		else $error("more pixels in flight than front, queue and back can hold");

endmodule

bind burning_ship_escape_time bse_checker u_bse_checker (.*);

@@ tb/sv/bse_pixel_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the burning ship core: shadows the registers, predicts each pixel, checks results.
module bse_pixel_checker #(
	parameter int IMG_W = bse_pkg::IMG_WIDTH_DEF,
	parameter int IMG_H = bse_pkg::IMG_HEIGHT_DEF,
	parameter int FRAC  = bse_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  bse_pkg::pixel_in_t               item,
	input  logic                             done,
	input  bse_pkg::pixel_out_t              result,
	input  logic                             cfg_we,
	input  logic [bse_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bse_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                               errors,
	output int                               pending,
	output int                               results_seen,
	output int                               escapes_seen
);
	import bse_pkg::*;

	localparam longint          S32_MAX      = 64'sd2147483647;
	localparam longint          S32_MIN      = -64'sd2147483648;
	localparam longint unsigned WHITE        = 64'hFFFFFF;
	localparam longint unsigned SHADE_STEP   = 64'd10000;
	localparam int              REPORT_LIMIT = 10;

	cfg_t       regs = CFG_RESET;
	pixel_out_t expected_pixels[$];
	int         n_bad = 0;
	int         n_results = 0;
	int         n_escaped = 0;

	function automatic longint clamp_s32(input longint v);
		if (v > S32_MAX) begin
			return S32_MAX;
		end
		if (v < S32_MIN) begin
			return S32_MIN;
		end
		return v;
	endfunction

	// |v| with the most negative value pinned to the largest positive
	function automatic longint fold_abs(input longint v);
		longint m;
		m = (v < 0) ? -v : v;
		return (m > S32_MAX) ? S32_MAX : m;
	endfunction

	function automatic longint place_axis(input longint coord, input longint extent,
			input longint zoom, input longint shift);
		longint m;
		m = clamp_s32((coord << (FRAC + 2)) / extent - (longint'(2) << FRAC));
		return clamp_s32(((m * zoom) >>> FRAC) + shift);
	endfunction

	function automatic pixel_out_t predict_pixel(input pixel_in_t px, input cfg_t c);
		longint          cr, ci, zr, zi, a, b, zoom;
		longint unsigned mag, bound, span, ramp, shade;
		int unsigned     step;
		pixel_out_t      r;
		zoom = longint'({33'b0, c.zoom_factor});
		cr = place_axis(longint'(px.column), longint'(IMG_W), zoom,
			longint'($signed(c.offset_real)));
		ci = place_axis(longint'(px.row), longint'(IMG_H), zoom,
			longint'($signed(c.offset_imag)));
		r.out_column  = px.column;
		r.out_row     = px.row;
		r.pixel_color = {8'h00, c.seed_color};
		r.escaped     = 1'b0;
		bound = longint'({33'b0, c.escape_threshold}) << FRAC;
		zr = cr;
		zi = ci;
		for (step = 0; step < c.iteration_limit; step++) begin
			a = fold_abs(zr);
			b = fold_abs(zi);
			zr = clamp_s32(((a * a - b * b) >>> FRAC) + cr);
			zi = clamp_s32(((2 * a * b) >>> FRAC) + ci);
			mag = longint'(zr * zr) + longint'(zi * zi);
			if (mag >= bound) begin
				span  = WHITE - c.seed_color;
				ramp  = (span * step) / c.iteration_limit;
				shade = c.seed_color + ramp + SHADE_STEP * c.color_offset;
				r.pixel_color = shade[31:0];
				r.escaped     = 1'b1;
				return r;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_out_t want;
		if (!arst_n) begin
			regs = CFG_RESET;
			expected_pixels.delete();
		end else begin
			if (done) begin
				n_results++;
				if (result.escaped) begin
					n_escaped++;
				end
				if (expected_pixels.size() == 0) begin
					if (n_bad < REPORT_LIMIT) begin
						$display("unexpected result beat: col %0d row %0d color %h escaped %b",
							result.out_column, result.out_row, result.pixel_color,
							result.escaped);
					end
					n_bad++;
				end else begin
					want = expected_pixels.pop_front();
					if (result.out_column !== want.out_column || result.out_row !== want.out_row
							|| result.pixel_color !== want.pixel_color
							|| result.escaped !== want.escaped) begin
						if (n_bad < REPORT_LIMIT) begin
							$display("mismatch: want col %0d row %0d color %h esc %b, got col %0d row %0d color %h esc %b",
								want.out_column, want.out_row, want.pixel_color, want.escaped,
								result.out_column, result.out_row, result.pixel_color,
								result.escaped);
						end
						n_bad++;
					end
				end
			end
			if (start && !busy) begin
				expected_pixels.push_back(predict_pixel(item, regs));
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ZOOM:         regs.zoom_factor      = cfg_data[30:0];
					CFG_OFFSET_REAL:  regs.offset_real      = cfg_data;
					CFG_OFFSET_IMAG:  regs.offset_imag      = cfg_data;
					CFG_ITER_LIMIT:   regs.iteration_limit  = cfg_data[ITER_W-1:0];
					CFG_ESC_THRESH:   regs.escape_threshold = cfg_data[30:0];
					CFG_SEED_COLOR:   regs.seed_color       = cfg_data[RGB_W-1:0];
					CFG_COLOR_OFFSET: regs.color_offset     = cfg_data[7:0];
					default: ;
				endcase
			end
		end
		errors       <= n_bad;
		pending      <= expected_pixels.size();
		results_seen <= n_results;
		escapes_seen <= n_escaped;
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the burning ship core: clock, reset, pixel and register stimulus, verdict.
module tb_top;
	import bse_pkg::*;

	localparam int                   ITEM_GOAL      = 1450;
	localparam int                   STALL_LIMIT    = 40000;
	localparam int                   SETTLE_CYCLES  = 100;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  done;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	pixel_in_t             item;
	pixel_out_t            result;

	int errors;
	int pending;
	int results_seen;
	int escapes_seen;
	int items_sent = 0;
	int settings_used = 0;
	int stall_cycles = 0;

	burning_ship_escape_time u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bse_pixel_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.done         (done),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.escapes_seen (escapes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// nothing accepted on either side for too long means the core hung
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d pixels outstanding", pending);
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
		start <= 1'b1;
		item  <= '{column: col, row: row};
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic idle_gap(input bit steady);
		int n;
		int pick;
		n = 0;
		pick = $urandom_range(0, 99);
		if (!steady) begin
			if (pick >= 60 && pick < 90) begin
				n = $urandom_range(1, 3);
			end else if (pick >= 90 && pick < 99) begin
				n = $urandom_range(4, 20);
			end else if (pick == 99) begin
				n = $urandom_range(50, 300);
			end
		end
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// step the clock first so the counter already holds the last accepted beat
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// unused upper bits carry junk, the core must drop them
	task automatic load_setting(input cfg_t s, input bit poke_unused);
		logic [31:0] junk;
		junk = $urandom();
		put_reg(CFG_ZOOM, {junk[31], s.zoom_factor});
		put_reg(CFG_OFFSET_REAL, s.offset_real);
		put_reg(CFG_OFFSET_IMAG, s.offset_imag);
		put_reg(CFG_ITER_LIMIT, {junk[31:ITER_W], s.iteration_limit});
		put_reg(CFG_ESC_THRESH, {junk[30], s.escape_threshold});
		put_reg(CFG_SEED_COLOR, {junk[7:0], s.seed_color});
		put_reg(CFG_COLOR_OFFSET, {junk[23:0], s.color_offset});
		if (poke_unused) begin
			put_reg(CFG_UNUSED_IDX, $urandom());
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [31:0] draw_offset();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
		end else if (pick < 8) begin
			return $urandom();
		end else if (pick == 8) begin
			return 32'h8000_0000;
		end
		return 32'h7FFF_FFFF;
	endfunction

	function automatic cfg_t draw_setting();
		cfg_t s;
		int   pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2, 3, 4: s.zoom_factor = 31'($urandom_range(32'h0080_0000, 32'h0800_0000));
			5, 9:          s.zoom_factor = 31'($urandom_range(32'h0001_0000, 32'h0080_0000));
			6:             s.zoom_factor = 31'($urandom());
			7:             s.zoom_factor = 31'h7FFF_FFFF;
			default:       s.zoom_factor = 31'($urandom_range(0, 1));
		endcase
		s.offset_real = draw_offset();
		s.offset_imag = draw_offset();
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			s.iteration_limit = 12'($urandom_range(1, 64));
		end else if (pick < 8) begin
			s.iteration_limit = 12'($urandom_range(65, 300));
		end else if (pick == 8) begin
			s.iteration_limit = 12'($urandom_range(301, 4095));
		end else begin
			case ($urandom_range(0, 2))
				0:       s.iteration_limit = 12'd0;
				1:       s.iteration_limit = 12'd1;
				default: s.iteration_limit = 12'hFFF;
			endcase
		end
		pick = $urandom_range(0, 9);
		case (pick)
			5, 6:    s.escape_threshold = 31'($urandom_range(32'h0100_0000, 32'h1000_0000));
			7:       s.escape_threshold = 31'($urandom());
			8:       s.escape_threshold = 31'd0;
			9:       s.escape_threshold = 31'h7FFF_FFFF;
			default: s.escape_threshold = 31'd67108864;
		endcase
		pick = $urandom_range(0, 9);
		s.seed_color   = (pick == 7) ? 24'h0 : (pick == 8) ? 24'hFFFFFF : 24'($urandom());
		pick = $urandom_range(0, 9);
		s.color_offset = (pick == 7) ? 8'h0 : (pick == 8) ? 8'hFF : 8'($urandom());
		return s;
	endfunction

	initial begin
		cfg_t               s;
		int                 n_items;
		int                 k;
		bit                 steady;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// register defaults: corners, center and a few inner points
		push_pixel(10'd0, 10'd0);
		push_pixel(10'd1023, 10'd1023);
		push_pixel(10'd0, 10'd1023);
		push_pixel(10'd1023, 10'd0);
		push_pixel(10'd512, 10'd512);
		push_pixel(10'd512, 10'd384);
		push_pixel(10'd700, 10'd300);
		wait_drained();

		// zero zoom puts the start point on the offsets, here at both extremes
		s = CFG_RESET;
		s.zoom_factor      = 31'd0;
		s.offset_real      = 32'h8000_0000;
		s.offset_imag      = 32'h7FFF_FFFF;
		s.iteration_limit  = 12'hFFF;
		s.escape_threshold = 31'h7FFF_FFFF;
		s.seed_color       = 24'hFFFFFF;
		s.color_offset     = 8'hFF;
		load_setting(s, 1'b1);
		push_pixel(10'd1023, 10'd0);
		push_pixel(10'd5, 10'd900);
		wait_drained();

		// orbit stuck at the origin runs the full limit and never escapes
		s.offset_real = 32'h0;
		s.offset_imag = 32'h0;
		load_setting(s, 1'b0);
		push_pixel(10'd333, 10'd777);
		wait_drained();

		// zero limit: no step, base colour
		s = CFG_RESET;
		s.iteration_limit = 12'd0;
		s.seed_color      = 24'h123456;
		s.color_offset    = 8'd77;
		load_setting(s, 1'b0);
		push_pixel(10'd0, 10'd0);
		push_pixel(10'd1023, 10'd1023);
		push_pixel(10'd512, 10'd512);
		wait_drained();

		// zero threshold: escapes on the first step
		s.iteration_limit  = 12'd1;
		s.escape_threshold = 31'd0;
		load_setting(s, 1'b0);
		push_pixel(10'd512, 10'd512);
		push_pixel(10'd77, 10'd901);
		wait_drained();

		// full zoom with extreme offsets drives adds into saturation
		s = CFG_RESET;
		s.zoom_factor      = 31'h7FFF_FFFF;
		s.offset_real      = 32'h7FFF_FFFF;
		s.offset_imag      = 32'h8000_0000;
		s.iteration_limit  = 12'd8;
		s.escape_threshold = 31'h7FFF_FFFF;
		s.seed_color       = 24'h00FF00;
		s.color_offset     = 8'd3;
		load_setting(s, 1'b1);
		push_pixel(10'd0, 10'd0);
		push_pixel(10'd1023, 10'd1023);
		push_pixel(10'd512, 10'd512);
		push_pixel(10'd0, 10'd1023);
		wait_drained();

		while (items_sent < ITEM_GOAL) begin
			s = draw_setting();
			load_setting(s, $urandom_range(0, 3) == 0);
			if (s.iteration_limit > 300) begin
				n_items = $urandom_range(2, 4);
			end else if (s.iteration_limit > 64) begin
				n_items = $urandom_range(20, 40);
			end else begin
				n_items = $urandom_range(60, 140);
			end
			if (n_items > ITEM_GOAL - items_sent) begin
				n_items = ITEM_GOAL - items_sent;
			end
			steady = ($urandom_range(0, 3) == 0);
			for (k = 0; k < n_items; k++) begin
				col = COORD_W'($urandom());
				row = COORD_W'($urandom());
				if ($urandom_range(0, 15) == 0) begin
					col = {COORD_W{col[0]}};
				end
				if ($urandom_range(0, 15) == 0) begin
					row = {COORD_W{row[0]}};
				end
				push_pixel(col, row);
				if ($urandom_range(0, 199) == 0) begin
					wait_drained();
				end else begin
					idle_gap(steady);
				end
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d pixels under %0d register settings, %0d results checked",
			items_sent, settings_used, results_seen);
		$display("%0d escaped, %0d stayed bounded", escapes_seen, results_seen - escapes_seen);
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/bse_pkg.sv
rtl/core/bse_front.sv
rtl/core/bse_fifo.sv
rtl/core/bse_back.sv
rtl/core/burning_ship_escape_time.sv
rtl/core/bse_checker.sv
tb/sv/bse_pixel_checker.sv
tb/sv/tb_top.sv
